### design/iieb_pkg.sv
// ============================================================================
// iieb_pkg
// Shared types and constants for the indexed insert/erase buffer.
// ============================================================================
`default_nettype none

package iieb_pkg;

    // Field widths of the request and response words.
    localparam int OP_W    = 2;
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 32;
    localparam int ERR_W   = 2;
    localparam int FILL_W  = 6;

    // Position bus width, wide enough for the largest supported store.
    localparam int POS_MAX_W = 10;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2,
        OP_APPEND = 2'd3
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    // What every cell of the chain does on each clock edge.
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_INSERT,
        ACT_ERASE
    } t_act;

    typedef struct packed {
        t_act                 act;
        logic [POS_MAX_W-1:0] pos;
    } t_cell_ctl;

    typedef struct packed {
        t_op                op;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] read_data;
        t_err               error;
        logic [FILL_W-1:0]  fill;
    } t_rsp;

endpackage

`default_nettype wire

### design/iieb_chan_if.sv
// ============================================================================
// iieb_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ============================================================================
`default_nettype none

interface iieb_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/indexed_insert_erase_buffer.sv
// ============================================================================
// indexed_insert_erase_buffer
// Ordered store with read, insert, erase and append at an index, built as a
// chain of shifting cells with a fill count.
// ============================================================================
//
//  Channel  Dir  Word    Contents
//  -------  ---  ------  ------------------------------------------------
//  i_req    in   t_req   op, index, value
//  o_rsp    out  t_rsp   read_data, error, fill (one word per request)
//
//  Every request is carried out on its accepting edge: the whole chain shifts
//  in parallel, and the response lands in the output register.
//  A new request is accepted while the previous response is being taken,
//  giving one request per cycle when the sink keeps ready high.
//  When the sink stalls, the response register holds and i_req.ready drops.
//  Reset is synchronous; it clears the fill count and the response valid
//  flag. Cell contents are left as they are.
// ============================================================================
`default_nettype none

module indexed_insert_erase_buffer
    import iieb_pkg::*;
#(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    iieb_chan_if.sink   i_req,
    iieb_chan_if.source o_rsp
);

    // Stored width: values are kept to the low DATA_WIDTH bits of the field.
    localparam int SW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    // Fill count width, able to hold CAPACITY itself.
    localparam int CW    = $clog2(CAPACITY + 1);
    // Compare width covering both the index field and the count.
    localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_rsp_valid;
    t_rsp           r_rsp;
    t_rsp           n_rsp;
    logic           w_accept;
    t_err           w_err;
    t_cell_ctl      w_ctl;
    logic [CMP_W-1:0] w_idx;
    logic [CMP_W-1:0] w_cnt;
    logic [SW-1:0]  w_value;
    logic [SW-1:0]  w_rd;
    logic [SW-1:0]  w_cell_data [CAPACITY];
    logic [SW-1:0]  w_cell_read [CAPACITY];

    // The input side opens whenever the response register is free or is
    // being emptied in this same cycle.
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_idx   = CMP_W'(i_req.payload.index);
    assign w_cnt   = CMP_W'(r_count);
    assign w_value = SW'(i_req.payload.value);

    // Request decode: checks the index against the fill count, then picks
    // the action that every cell carries out. An append is an insert at the
    // current fill count.
    always_comb begin
        w_err     = ERR_OK;
        n_count   = r_count;
        w_ctl.act = ACT_HOLD;
        w_ctl.pos = POS_MAX_W'(i_req.payload.index);
        unique case (i_req.payload.op)
            OP_READ: begin
                if (w_idx >= w_cnt) begin
                    w_err = ERR_RANGE;
                end
            end
            OP_INSERT: begin
                if (w_idx > w_cnt) begin
                    w_err = ERR_RANGE;
                end else if (r_count == CW'(CAPACITY)) begin
                    w_err = ERR_FULL;
                end else begin
                    w_ctl.act = ACT_INSERT;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_ERASE: begin
                if (w_idx >= w_cnt) begin
                    w_err = ERR_RANGE;
                end else begin
                    w_ctl.act = ACT_ERASE;
                    n_count   = r_count - CW'(1);
                end
            end
            OP_APPEND: begin
                if (r_count == CW'(CAPACITY)) begin
                    w_err = ERR_FULL;
                end else begin
                    w_ctl.act = ACT_INSERT;
                    w_ctl.pos = POS_MAX_W'(r_count);
                    n_count   = r_count + CW'(1);
                end
            end
            default: w_err = ERR_OK;
        endcase
        // Nothing moves unless a request is actually taken.
        if (!w_accept) begin
            w_ctl.act = ACT_HOLD;
            n_count   = r_count;
        end
    end

    // The chain of cells. The first cell never loads from the left, and the
    // last cell holds its own word during an erase.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [SW-1:0] w_left;
        logic [SW-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_data[g];
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end

        iieb_cell #(
            .DATA_W (SW),
            .POS    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_value (w_value),
            .o_data  (w_cell_data[g]),
            .o_read  (w_cell_read[g])
        );
    end

    // Only the addressed cell drives a nonzero read word, so an OR across
    // the chain selects it.
    always_comb begin
        w_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd = w_rd | w_cell_read[k];
        end
    end

    always_comb begin
        n_rsp.error = w_err;
        n_rsp.fill  = FILL_W'(n_count);
        if (i_req.payload.op == OP_READ && w_err == ERR_OK) begin
            n_rsp.read_data = VALUE_W'(w_rd);
        end else begin
            n_rsp.read_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");

    // A refused request leaves the fill count alone.
    a_err_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_err != ERR_OK) |=> $stable(r_count))
        else $error("fill count changed on a refused request");

    // Each accepted request yields a response whose fill matches the count.
    a_rsp_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_rsp_valid && r_rsp.fill == FILL_W'(r_count)))
        else $error("response missing or fill out of step with count");

    // A successful insert grows the store by exactly one entry.
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_ctl.act == ACT_INSERT)
            |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the store by one");

    // A failed request never returns data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_rsp.error != ERR_OK) |-> r_rsp.read_data == '0)
        else $error("data returned with an error response");

endmodule

`default_nettype wire

### design/iieb_cell.sv
// ============================================================================
// iieb_cell
// One storage slot of the insertion chain; loads from its neighbor or the
// new value as the broadcast control word directs.
// ============================================================================
`default_nettype none

module iieb_cell
    import iieb_pkg::*;
#(
    parameter int DATA_W = 32,
    parameter int POS    = 0
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [DATA_W-1:0] i_left,
    input  wire logic [DATA_W-1:0] i_right,
    input  wire logic [DATA_W-1:0] i_value,
    output logic      [DATA_W-1:0] o_data,
    output logic      [DATA_W-1:0] o_read
);

    localparam logic [POS_MAX_W-1:0] MY_POS = POS_MAX_W'(POS);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // Slots beyond the fill count hold don't-care data, so they may shift
    // freely along with the valid ones.
    always_comb begin
        n_data = r_data;
        case (i_ctl.act)
            ACT_INSERT: begin
                if (MY_POS == i_ctl.pos) begin
                    n_data = i_value;
                end else if (MY_POS > i_ctl.pos) begin
                    n_data = i_left;
                end
            end
            ACT_ERASE: begin
                if (MY_POS >= i_ctl.pos) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_read = (MY_POS == i_ctl.pos) ? r_data : '0;

endmodule

`default_nettype wire

### tb/iieb_list_checker.sv
// ============================================================================
// iieb_list_checker
// Watches both channels of the insert/erase buffer, keeps its own ordered
// store and fill count, and checks every response word against it.
// ============================================================================

module iieb_list_checker
    import iieb_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req_word,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp_word,
    output int   o_fail_count,
    output int   o_pending_words,
    output int   o_model_fill,
    output int   o_checked_words,
    output int   o_range_errors,
    output int   o_full_errors,
    output int   o_peak_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOWN_MISMATCHES = 20;

    logic [VALUE_W-1:0] list_cells [CAPACITY];
    int unsigned        list_fill = 0;
    t_rsp               expected_rsp_q [$];

    int fail_count    = 0;
    int checked_words = 0;
    int range_errors  = 0;
    int full_errors   = 0;
    int peak_fill     = 0;

    assign o_fail_count    = fail_count;
    assign o_checked_words = checked_words;
    assign o_range_errors  = range_errors;
    assign o_full_errors   = full_errors;
    assign o_peak_fill     = peak_fill;
    assign o_model_fill    = list_fill;
    assign o_pending_words = expected_rsp_q.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= SHOWN_MISMATCHES) begin
            $display("%0t ns: mismatch in %s on response word %0d: got %h, expected %h",
                     $realtime, what, checked_words, got, want);
        end
    endtask

    // Carries out one request on the local store and gives the response word
    // that the buffer must produce for it.
    task automatic apply_request(input t_req w, output t_rsp r);
        int unsigned idx;
        idx = w.index;
        r = '0;
        r.error = ERR_OK;
        case (w.op)
            OP_READ: begin
                if (idx < list_fill) begin
                    r.read_data = list_cells[idx];
                end else begin
                    r.error = ERR_RANGE;
                end
            end
            OP_INSERT: begin
                // The range test wins over the full test.
                if (idx > list_fill) begin
                    r.error = ERR_RANGE;
                end else if (list_fill >= CAPACITY) begin
                    r.error = ERR_FULL;
                end else begin
                    for (int i = list_fill; i > idx; i--) list_cells[i] = list_cells[i-1];
                    list_cells[idx] = w.value;
                    list_fill++;
                end
            end
            OP_ERASE: begin
                if (idx >= list_fill) begin
                    r.error = ERR_RANGE;
                end else begin
                    for (int i = idx; i + 1 < list_fill; i++) list_cells[i] = list_cells[i+1];
                    list_fill--;
                end
            end
            default: begin
                if (list_fill >= CAPACITY) begin
                    r.error = ERR_FULL;
                end else begin
                    list_cells[list_fill] = w.value;
                    list_fill++;
                end
            end
        endcase
        r.fill = list_fill[FILL_W-1:0];
    endtask

    // A response taken on the same edge as a request belongs to an earlier
    // request, so the comparison runs before the new prediction is queued.
    always @(posedge i_clk) begin : track
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            list_fill = 0;
            expected_rsp_q.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_word;
                checked_words++;
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("unexpected response word", got.read_data, '0);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.error !== want.error)
                        report_mismatch("error", 32'(got.error), 32'(want.error));
                    if (got.fill !== want.fill)
                        report_mismatch("fill", 32'(got.fill), 32'(want.fill));
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(i_req_word, want);
                expected_rsp_q = {expected_rsp_q, want};
                if (want.error == ERR_RANGE) range_errors++;
                if (want.error == ERR_FULL) full_errors++;
                if (list_fill > peak_fill) peak_fill = list_fill;
            end
        end
    end

endmodule

### tb/tb.sv
// ============================================================================
// tb
// Stimulus and verdict for the indexed insert/erase buffer: a short directed
// list of corner cases, then random requests that swing the store between
// empty and full, with random idling on both channels and one long stall of
// the response side.
// ============================================================================

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iieb_pkg::*;

    localparam int CAPACITY        = 32;
    localparam int RANDOM_WORDS    = 580;
    // The last words of the run go through with no idling on either side.
    localparam int CALM_WORDS      = 100;
    // Where the long hold-off of the response side is started.
    localparam int PRESSURE_AT     = 200;
    localparam int PRESSURE_WORDS  = 40;
    localparam int HOLD_OFF_CYCLES = 80;
    // Longest run of cycles without any handshake before the run is abandoned.
    // The slowest correct stretch is the hold-off plus a random burst or two.
    localparam int WATCHDOG_LIMIT  = 3000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #10 i_clk = ~i_clk;

    iieb_chan_if #(.t_payload(t_req)) req_if ();
    iieb_chan_if #(.t_payload(t_rsp)) rsp_if ();

    indexed_insert_erase_buffer #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (VALUE_W)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    int fail_count;
    int pending_words;
    int model_fill;
    int checked_words;
    int range_errors;
    int full_errors;
    int peak_fill;

    iieb_list_checker #(.CAPACITY(CAPACITY)) u_list_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_if.valid),
        .i_req_ready     (req_if.ready),
        .i_req_word      (req_if.payload),
        .i_rsp_valid     (rsp_if.valid),
        .i_rsp_ready     (rsp_if.ready),
        .i_rsp_word      (rsp_if.payload),
        .o_fail_count    (fail_count),
        .o_pending_words (pending_words),
        .o_model_fill    (model_fill),
        .o_checked_words (checked_words),
        .o_range_errors  (range_errors),
        .o_full_errors   (full_errors),
        .o_peak_fill     (peak_fill)
    );

    // Shared between the two sides: calm switches idling off for the tail of
    // the run, and hold_off_pending asks the response side for a long stall.
    bit calm             = 1'b0;
    bit hold_off_pending = 1'b0;
    // The random requests alternate between filling the store and draining it.
    bit grow_phase       = 1'b1;
    int words_sent [4]   = '{default: 0};
    int idle_cycles      = 0;

    // ------------------------------------------------------------------------
    // Watchdog: counts cycles in which neither channel moves a word.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Response side. Ready changes only on falling edges. Each pass of the
    // loop is one burst: ready high for a while, a random stall, or the long
    // hold-off that the request side asked for. The hold-off is counted here
    // so that the request side keeps offering words the whole time.
    // ------------------------------------------------------------------------
    initial begin : response_side
        rsp_if.ready <= 1'b0;
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk) rsp_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 17)) @(negedge i_clk) rsp_if.ready <= 1'b0;
            end else begin
                repeat ($urandom_range(1, 24)) @(negedge i_clk) rsp_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side helpers.
    // ------------------------------------------------------------------------

    // Presents a word (the caller is already on a falling edge) and holds it
    // until a rising edge sees valid and ready together.
    task automatic drive(input t_req w);
        req_if.valid   <= 1'b1;
        req_if.payload <= w;
        words_sent[int'(w.op)]++;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // With one chance in four, a random gap before the next word, outside the tail.
    task automatic source_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 17)) @(negedge i_clk) req_if.valid <= 1'b0;
        end
    endtask

    task automatic send_fixed(input t_op op, input logic [INDEX_W-1:0] idx,
                              input logic [VALUE_W-1:0] val);
        t_req w;
        w.op    = op;
        w.index = idx;
        w.value = val;
        source_gap();
        @(negedge i_clk);
        drive(w);
    endtask

    // Picks the next random request. It runs on a falling edge, after the
    // checker has taken in every word accepted so far, so model_fill is the
    // fill that this request will meet.
    function automatic t_req next_random_word();
        t_req        w;
        int unsigned fill;
        int unsigned pick;
        fill = model_fill;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0:       w.value = '0;
            1:       w.value = '1;
            default: w.value = $urandom();
        endcase
        // Stay at full for a few words so that full-store errors show up, and
        // likewise at empty; now and then turn around halfway.
        if (grow_phase && fill == CAPACITY && $urandom_range(0, 3) == 0) begin
            grow_phase = 1'b0;
        end else if (!grow_phase && fill == 0 && $urandom_range(0, 1) == 0) begin
            grow_phase = 1'b1;
        end else if ($urandom_range(0, 59) == 0) begin
            grow_phase = !grow_phase;
        end
        if (pick < 10) begin
            // Noise: any operation at any index the field can carry.
            w.op    = t_op'($urandom_range(0, 3));
            w.index = INDEX_W'($urandom_range(0, 63));
        end else if (grow_phase) begin
            if (pick < 45) begin
                w.op    = OP_APPEND;
                w.index = INDEX_W'($urandom_range(0, 63));
            end else if (pick < 80) begin
                // At full, an index beyond the count must give a range error
                // rather than a full-store error.
                w.op    = OP_INSERT;
                w.index = (fill == CAPACITY) ? INDEX_W'($urandom_range(0, 63))
                                             : INDEX_W'($urandom_range(0, fill));
            end else begin
                w.op    = OP_READ;
                w.index = INDEX_W'($urandom_range(0, fill));
            end
        end else begin
            if (pick < 60) begin
                w.op    = OP_ERASE;
                w.index = INDEX_W'($urandom_range(0, fill));
            end else if (pick < 80) begin
                w.op    = OP_READ;
                w.index = INDEX_W'($urandom_range(0, fill));
            end else begin
                w.op    = OP_INSERT;
                w.index = INDEX_W'($urandom_range(0, fill));
            end
        end
        return w;
    endfunction

    task automatic send_random();
        t_req w;
        @(negedge i_clk);
        w = next_random_word();
        drive(w);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : request_side
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        i_rst_n        <= 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from an empty store. The fill after each
        // word is noted on the right.
        send_fixed(OP_READ,   6'd0,  32'h0);          // read of empty store, 0
        send_fixed(OP_ERASE,  6'd0,  32'h0);          // erase of empty store, 0
        send_fixed(OP_INSERT, 6'd1,  32'h1111_1111);  // insert above count, 0
        send_fixed(OP_INSERT, 6'd0,  32'hFFFF_FFFF);  // 1
        send_fixed(OP_APPEND, 6'd63, 32'h0000_0000);  // 2
        send_fixed(OP_INSERT, 6'd2,  32'h1234_5678);  // insert at count, 3
        send_fixed(OP_INSERT, 6'd1,  32'hA5A5_A5A5);  // insert in the middle, 4
        send_fixed(OP_READ,   6'd0,  32'hFFFF_FFFF);
        send_fixed(OP_READ,   6'd1,  32'h0);
        send_fixed(OP_READ,   6'd2,  32'h0);
        send_fixed(OP_READ,   6'd3,  32'h0);
        send_fixed(OP_READ,   6'd4,  32'h0);          // read at count
        send_fixed(OP_READ,   6'd63, 32'h0);          // largest index
        send_fixed(OP_INSERT, 6'd63, 32'hDEAD_BEEF);  // insert far above count
        send_fixed(OP_ERASE,  6'd63, 32'h0);          // erase far above count
        send_fixed(OP_ERASE,  6'd3,  32'h0);          // erase the last entry, 3
        send_fixed(OP_ERASE,  6'd0,  32'h0);          // erase the first entry, 2
        send_fixed(OP_READ,   6'd0,  32'h0);
        send_fixed(OP_READ,   6'd1,  32'h0);
        send_fixed(OP_APPEND, 6'd0,  32'h5A5A_5A5A);  // 3
        send_fixed(OP_ERASE,  6'd1,  32'h0);          // erase in the middle, 2
        send_fixed(OP_READ,   6'd1,  32'h0);

        // Random part. Full and empty stores, and the errors they bring, are
        // reached by the filling and draining phases.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
            if (n == PRESSURE_AT) begin
                // Ask for the long stall and keep offering words back to back,
                // so the response register fills and the input backs up.
                hold_off_pending = 1'b1;
                repeat (PRESSURE_WORDS) send_random();
            end
            source_gap();
            send_random();
        end
        @(negedge i_clk);
        req_if.valid <= 1'b0;

        // Drain: wait for every expected response, then go on waiting so as to
        // catch any stray word. The watchdog bounds the wait.
        while (pending_words != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Sent %0d reads, %0d inserts, %0d erases and %0d appends;",
                 words_sent[int'(OP_READ)], words_sent[int'(OP_INSERT)],
                 words_sent[int'(OP_ERASE)], words_sent[int'(OP_APPEND)]);
        $display("checked %0d responses, saw %0d out-of-range and %0d full-store errors;",
                 checked_words, range_errors, full_errors);
        $display("the store peaked at %0d of %0d.", peak_fill, CAPACITY);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
